/* rtl/vcw_pkg.sv */
// ----------------------------------------------------------------------------
// vcw_pkg
// Shared types and constants for the vertex cluster weld block.
// ----------------------------------------------------------------------------
package vcw_pkg;

  localparam int MAX_SLOTS    = 16384;
  localparam int MAX_VERTICES = 16384;
  localparam int ADDR_W       = 14;
  localparam int CNT_W        = 15;
  localparam int SUM_W        = 47;
  localparam int BORDER_QUANT = 10000;
  localparam int MIN_STRIP    = 66;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_ADD    = 2'd1,
    CMD_READ   = 2'd2,
    CMD_REMAP  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_RANGE  = 2'd2,
    ST_BADCFG = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    REG_MIN_X  = 3'd0,
    REG_MIN_Y  = 3'd1,
    REG_MIN_Z  = 3'd2,
    REG_MAX_X  = 3'd3,
    REG_MAX_Y  = 3'd4,
    REG_MAX_Z  = 3'd5,
    REG_STRIP  = 3'd6,
    REG_INV    = 3'd7
  } reg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_KMUL, S_KFIN, S_SCAN_RD, S_SCAN_CMP, S_INSERT,
    S_UPDATE, S_RD_SLOT, S_RD_WAIT, S_DIV_GO, S_DIV_WAIT, S_VRD, S_VWAIT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic signed [2:0][31:0] bmin;
    logic signed [2:0][31:0] bmax;
    logic [30:0]             strip;
    logic [31:0]             inv_cluster;
  } cfg_t;

  typedef struct packed {
    logic signed [2:0][31:0]    key;
    logic                       border;
    logic signed [2:0][SUM_W-1:0] sum;
    logic [CNT_W-1:0]           cnt;
    logic signed [2:0][31:0]    exact;
    logic [ADDR_W-1:0]          first;
  } slot_t;

endpackage

/* rtl/vcw_div.sv */
// ----------------------------------------------------------------------------
// vcw_div
// Restoring divider, one quotient bit per cycle, for slot averages.
// ----------------------------------------------------------------------------
module vcw_div import vcw_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [SUM_W-1:0] dividend,
  input  logic [CNT_W-1:0] divisor,
  output logic             done,
  output logic [SUM_W-1:0] quotient
);

  logic             running;
  logic [5:0]       count;
  logic [CNT_W-1:0] rem;
  logic [CNT_W-1:0] dvs;
  logic [CNT_W:0]   rem_sh;
  logic             fits;

  assign rem_sh = {rem, quotient[SUM_W-1]};
  assign fits   = rem_sh >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      count   <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        count   <= '0;
      end else if (running) begin
        count <= count + 6'd1;
        if (count == 6'(SUM_W - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      dvs      <= divisor;
    end else if (running) begin
      if (fits) begin
        rem <= CNT_W'(rem_sh - {1'b0, dvs});
      end else begin
        rem <= rem_sh[CNT_W-1:0];
      end
      quotient <= {quotient[SUM_W-2:0], fits};
    end
  end

endmodule

/* rtl/vcw_core.sv */
// ----------------------------------------------------------------------------
// vcw_core
// Command sequencer with the slot table, the vertex remap table, one shared
// key multiplier and the average divider.
// ----------------------------------------------------------------------------
module vcw_core import vcw_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  cfg_t                cfg,
  input  logic                start,
  input  logic [1:0]          cmd,
  input  logic signed [31:0]  pos_x,
  input  logic signed [31:0]  pos_y,
  input  logic signed [31:0]  pos_z,
  input  logic [ADDR_W-1:0]   corner_a,
  input  logic [ADDR_W-1:0]   corner_b,
  input  logic [ADDR_W-1:0]   corner_c,
  output logic                busy,
  output logic                done,
  output logic [1:0]          status,
  output logic [ADDR_W-1:0]   slot_index,
  output logic signed [31:0]  weld_x,
  output logic signed [31:0]  weld_y,
  output logic signed [31:0]  weld_z,
  output logic [ADDR_W-1:0]   source_vertex,
  output logic [ADDR_W-1:0]   tri_a,
  output logic [ADDR_W-1:0]   tri_b,
  output logic [ADDR_W-1:0]   tri_c,
  output logic                degenerate,
  output logic [CNT_W-1:0]    slot_total
);

  state_t state, state_next;

  slot_t             slot_mem [MAX_SLOTS];
  logic [ADDR_W-1:0] v2s_mem  [MAX_VERTICES];
  slot_t             slot_q;
  logic [ADDR_W-1:0] v2s_q;

  cmd_t                     cmd_r;
  logic signed [2:0][31:0]  p;
  logic [2:0][ADDR_W-1:0]   corner;
  logic                     nb;
  logic signed [2:0][31:0]  key;
  logic [1:0]               axis;
  logic [CNT_W-1:0]         scan;
  logic [63:0]              prod;
  logic [CNT_W-1:0]         slots_used;
  logic [CNT_W-1:0]         vseen;
  logic signed [2:0][31:0]  weld;
  logic [2:0][ADDR_W-1:0]   tri_r;

  // Memory controls from the sequencer.
  logic              slot_re, slot_we, v2s_re, v2s_we;
  logic [ADDR_W-1:0] slot_addr, v2s_addr;
  slot_t             slot_wdata;

  // Border test, key multiplier and key finish.
  logic [30:0]       strip_eff;
  logic [2:0]        near;
  logic [31:0]       mag_p;
  logic [31:0]       mul_b;
  logic [44:0]       bk_round;
  logic [32:0]       ck_neg;
  logic signed [31:0] key_new;
  logic              match;

  // Divider hookup.
  logic             div_start, div_done;
  logic [SUM_W-1:0] div_q, sum_mag;
  logic signed [SUM_W-1:0] sum_sel;
  logic [31:0]      avg_w;

  always_comb begin
    logic signed [33:0] d_lo, d_hi;
    strip_eff = (cfg.strip > 31'(MIN_STRIP)) ? cfg.strip : 31'(MIN_STRIP);
    for (int i = 0; i < 3; i++) begin
      d_lo = 34'($signed(p[i])) - 34'($signed(cfg.bmin[i]));
      d_hi = 34'($signed(cfg.bmax[i])) - 34'($signed(p[i]));
      near[i] = (d_lo < $signed({3'b000, strip_eff})) ||
                (d_hi < $signed({3'b000, strip_eff}));
    end
  end

  assign mag_p    = p[axis][31] ? 32'(-p[axis]) : p[axis];
  assign mul_b    = nb ? 32'(BORDER_QUANT) : cfg.inv_cluster;
  assign bk_round = 45'((prod + 64'd32768) >> 16);
  assign ck_neg   = 33'((prod + 64'hFFFF_FFFF) >> 32);

  always_comb begin
    if (nb) begin
      key_new = p[axis][31] ? -$signed(bk_round[31:0]) : $signed(bk_round[31:0]);
    end else if (p[axis][31]) begin
      key_new = 32'(-ck_neg);
    end else begin
      key_new = prod[63:32];
    end
  end

  assign match = (slot_q.border == nb) && (slot_q.key == key);

  assign sum_sel = slot_q.sum[axis];
  assign sum_mag = sum_sel[SUM_W-1] ? SUM_W'(-sum_sel) : sum_sel;
  assign avg_w   = sum_sel[SUM_W-1] ? 32'(-div_q[31:0]) : div_q[31:0];

  vcw_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sum_mag),
    .divisor  (slot_q.cnt),
    .done     (div_done),
    .quotient (div_q)
  );

  // Slot word for a new slot or an update of the matched slot.
  always_comb begin
    slot_wdata = slot_q;
    if (state == S_INSERT) begin
      slot_wdata.key    = key;
      slot_wdata.border = nb;
      for (int i = 0; i < 3; i++) begin
        slot_wdata.sum[i]   = SUM_W'($signed(p[i]));
        slot_wdata.exact[i] = p[i];
      end
      slot_wdata.cnt   = CNT_W'(1);
      slot_wdata.first = vseen[ADDR_W-1:0];
    end else begin
      for (int i = 0; i < 3; i++) begin
        slot_wdata.sum[i] = slot_q.sum[i] + SUM_W'($signed(p[i]));
      end
      slot_wdata.cnt = slot_q.cnt + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (slot_we) begin
      slot_mem[slot_addr] <= slot_wdata;
    end
    if (slot_re) begin
      slot_q <= slot_mem[slot_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (v2s_we) begin
      v2s_mem[v2s_addr] <= (state == S_INSERT) ? slots_used[ADDR_W-1:0]
                                              : scan[ADDR_W-1:0];
    end
    if (v2s_re) begin
      v2s_q <= v2s_mem[v2s_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    slot_re    = 1'b0;
    slot_we    = 1'b0;
    slot_addr  = scan[ADDR_W-1:0];
    v2s_re     = 1'b0;
    v2s_we     = 1'b0;
    v2s_addr   = vseen[ADDR_W-1:0];
    div_start  = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        unique case (cmd_r)
          CMD_CLEAR: state_next = S_DONE;
          CMD_ADD: begin
            if (cfg.inv_cluster == '0 || vseen >= CNT_W'(MAX_VERTICES)) begin
              state_next = S_DONE;
            end else begin
              state_next = S_KMUL;
            end
          end
          CMD_READ: begin
            state_next = ({1'b0, corner[0]} >= slots_used) ? S_DONE : S_RD_SLOT;
          end
          CMD_REMAP: begin
            if ({1'b0, corner[0]} >= vseen || {1'b0, corner[1]} >= vseen ||
                {1'b0, corner[2]} >= vseen) begin
              state_next = S_DONE;
            end else begin
              state_next = S_VRD;
            end
          end
          default: state_next = S_DONE;
        endcase
      end
      S_KMUL: state_next = S_KFIN;
      S_KFIN: state_next = (axis == 2'd2) ? S_SCAN_RD : S_KMUL;
      S_SCAN_RD: begin
        if (scan == slots_used) begin
          state_next = S_INSERT;
        end else begin
          slot_re    = 1'b1;
          state_next = S_SCAN_CMP;
        end
      end
      S_SCAN_CMP: state_next = match ? S_UPDATE : S_SCAN_RD;
      S_INSERT: begin
        slot_addr = slots_used[ADDR_W-1:0];
        if (slots_used < CNT_W'(MAX_SLOTS)) begin
          slot_we = 1'b1;
          v2s_we  = 1'b1;
        end
        state_next = S_DONE;
      end
      S_UPDATE: begin
        slot_we    = 1'b1;
        v2s_we     = 1'b1;
        state_next = S_DONE;
      end
      S_RD_SLOT: begin
        slot_addr  = corner[0];
        slot_re    = 1'b1;
        state_next = S_RD_WAIT;
      end
      S_RD_WAIT: state_next = slot_q.border ? S_DONE : S_DIV_GO;
      S_DIV_GO: begin
        div_start  = 1'b1;
        state_next = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (div_done) begin
          state_next = (axis == 2'd2) ? S_DONE : S_DIV_GO;
        end
      end
      S_VRD: begin
        v2s_addr   = corner[axis];
        v2s_re     = 1'b1;
        state_next = S_VWAIT;
      end
      S_VWAIT: state_next = (axis == 2'd2) ? S_DONE : S_VRD;
      S_DONE:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slots_used <= '0;
      vseen      <= '0;
    end else if (state == S_CHECK && cmd_r == CMD_CLEAR) begin
      slots_used <= '0;
      vseen      <= '0;
    end else if (state == S_INSERT && slots_used < CNT_W'(MAX_SLOTS)) begin
      slots_used <= slots_used + CNT_W'(1);
      vseen      <= vseen + CNT_W'(1);
    end else if (state == S_UPDATE) begin
      vseen <= vseen + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        cmd_r      <= cmd_t'(cmd);
        p          <= {pos_z, pos_y, pos_x};
        corner     <= {corner_c, corner_b, corner_a};
        axis       <= '0;
        scan       <= '0;
        status     <= ST_OK;
        slot_index <= '0;
        weld       <= '0;
        source_vertex <= '0;
        tri_r      <= '0;
        degenerate <= 1'b0;
      end
      S_CHECK: begin
        nb <= |near;
        unique case (cmd_r)
          CMD_ADD: begin
            if (cfg.inv_cluster == '0) begin
              status <= ST_BADCFG;
            end else if (vseen >= CNT_W'(MAX_VERTICES)) begin
              status <= ST_FULL;
            end
          end
          CMD_READ: begin
            if ({1'b0, corner[0]} >= slots_used) begin
              status <= ST_RANGE;
            end
          end
          CMD_REMAP: begin
            if ({1'b0, corner[0]} >= vseen || {1'b0, corner[1]} >= vseen ||
                {1'b0, corner[2]} >= vseen) begin
              status <= ST_RANGE;
            end
          end
          default: ;
        endcase
      end
      S_KMUL: prod <= 64'(mag_p) * 64'(mul_b);
      S_KFIN: begin
        key[axis] <= key_new;
        axis      <= axis + 2'd1;
      end
      S_SCAN_CMP: begin
        if (!match) begin
          scan <= scan + CNT_W'(1);
        end
      end
      S_INSERT: begin
        if (slots_used < CNT_W'(MAX_SLOTS)) begin
          slot_index <= slots_used[ADDR_W-1:0];
        end else begin
          status <= ST_FULL;
        end
      end
      S_UPDATE: slot_index <= scan[ADDR_W-1:0];
      S_RD_WAIT: begin
        source_vertex <= slot_q.first;
        axis          <= '0;
        if (slot_q.border) begin
          weld <= slot_q.exact;
        end
      end
      S_DIV_WAIT: begin
        if (div_done) begin
          weld[axis] <= avg_w;
          axis       <= axis + 2'd1;
        end
      end
      S_VWAIT: begin
        tri_r[axis] <= v2s_q;
        axis        <= axis + 2'd1;
        if (axis == 2'd2) begin
          degenerate <= (tri_r[0] == tri_r[1]) || (tri_r[1] == v2s_q) ||
                        (tri_r[0] == v2s_q);
        end
      end
      default: ;
    endcase
  end

  assign busy       = (state != S_IDLE);
  assign done       = (state == S_DONE);
  assign weld_x     = weld[0];
  assign weld_y     = weld[1];
  assign weld_z     = weld[2];
  assign tri_a      = tri_r[0];
  assign tri_b      = tri_r[1];
  assign tri_c      = tri_r[2];
  assign slot_total = slots_used;

endmodule

/* rtl/vertex_cluster_weld.sv */
// ----------------------------------------------------------------------------
// vertex_cluster_weld
// Welds mesh vertices into grid clusters and remaps triangles onto slots.
// ----------------------------------------------------------------------------
// Channel   Handshake             Payload
// command   start, busy           cmd, pos_x/y/z, corner_a/b/c
// result    done (one cycle)      status, slot_index, weld_x/y/z,
//                                 source_vertex, tri_a/b/c, degenerate,
//                                 slot_total
// config    wr_en                 wr_index, wr_data
//
// Clear and failed checks go from the check state straight to the result.
// Add vertex time is set by the linear key search through the slot memory,
// and the search runs longer when a new slot is appended.
// Read slot skips the divider for a border slot; an interior slot runs three
// passes of the 47-step divider. Remap reads the three corners in turn.
// Reset empties both tables at once; there is no clearing pass.
// Results cannot be stalled; busy stays high until the result cycle ends.
module vertex_cluster_weld import vcw_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_en,
  input  logic [2:0]         wr_index,
  input  logic [31:0]        wr_data,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         cmd,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] pos_z,
  input  logic [13:0]        corner_a,
  input  logic [13:0]        corner_b,
  input  logic [13:0]        corner_c,
  output logic               done,
  output logic [1:0]         status,
  output logic [13:0]        slot_index,
  output logic signed [31:0] weld_x,
  output logic signed [31:0] weld_y,
  output logic signed [31:0] weld_z,
  output logic [13:0]        source_vertex,
  output logic [13:0]        tri_a,
  output logic [13:0]        tri_b,
  output logic [13:0]        tri_c,
  output logic               degenerate,
  output logic [14:0]        slot_total
);

  cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.bmin        <= '0;
      cfg.bmax        <= '0;
      cfg.strip       <= 31'(MIN_STRIP);
      cfg.inv_cluster <= 32'd65536;
    end else if (wr_en) begin
      unique case (reg_idx_t'(wr_index))
        REG_MIN_X: cfg.bmin[0]      <= wr_data;
        REG_MIN_Y: cfg.bmin[1]      <= wr_data;
        REG_MIN_Z: cfg.bmin[2]      <= wr_data;
        REG_MAX_X: cfg.bmax[0]      <= wr_data;
        REG_MAX_Y: cfg.bmax[1]      <= wr_data;
        REG_MAX_Z: cfg.bmax[2]      <= wr_data;
        REG_STRIP: cfg.strip        <= wr_data[30:0];
        REG_INV:   cfg.inv_cluster  <= wr_data;
        default: ;
      endcase
    end
  end

  vcw_core u_core (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .start         (start),
    .cmd           (cmd),
    .pos_x         (pos_x),
    .pos_y         (pos_y),
    .pos_z         (pos_z),
    .corner_a      (corner_a),
    .corner_b      (corner_b),
    .corner_c      (corner_c),
    .busy          (busy),
    .done          (done),
    .status        (status),
    .slot_index    (slot_index),
    .weld_x        (weld_x),
    .weld_y        (weld_y),
    .weld_z        (weld_z),
    .source_vertex (source_vertex),
    .tri_a         (tri_a),
    .tri_b         (tri_b),
    .tri_c         (tri_c),
    .degenerate    (degenerate),
    .slot_total    (slot_total)
  );

  // An accepted item keeps the block busy until its result is shown.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy && !done) else $error("accept did not start work");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done && !busy) else $error("result held longer than one cycle");

  a_slot_bound: assert property (@(posedge clk) disable iff (rst)
    slot_total <= 15'(MAX_SLOTS)) else $error("slot count beyond table size");

  a_degenerate_only_remap: assert property (@(posedge clk) disable iff (rst)
    done && status != ST_OK |-> !degenerate && slot_index == '0)
    else $error("failed item carries payload");

endmodule
